// ===== hdl/mmhh_pkg.sv =====
package mmhh_pkg;

  // field widths
  localparam int DEMAND_W   = 16;
  localparam int GYRO_W     = 24;
  localparam int ERR_W      = 25;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = 41;
  localparam int ROT_W      = 17;
  localparam int WHEEL_W    = 18;
  localparam int MAG_W      = 17;
  localparam int THR_W      = 15;
  localparam int WIN_W      = 16;
  localparam int QUOT_W     = 16;
  localparam int NUM_W      = 32;
  localparam int DCNT_W     = 3;
  localparam int STEP_W     = 4;
  localparam int REG_ADDR_W = 4;
  localparam int APB_W      = 32;

  // fixed point constants
  localparam logic [MAG_W-1:0]         UNITY       = 17'd16384;
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = 41'sd128;
  localparam logic signed [PROD_W-1:0] ROT_SAT_HI  = 41'sd32768;
  localparam logic signed [PROD_W-1:0] ROT_SAT_LO  = -41'sd32768;
  localparam logic signed [ROT_W-1:0]  ROT_MAX     = 17'sd32768;
  localparam logic signed [ROT_W-1:0]  ROT_MIN     = -17'sd32768;
  localparam logic [DCNT_W-1:0]        DIV_STEPS   = 3'd7;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd256;
  localparam logic [THR_W-1:0]  THRESH_RESET   = 15'd1638;
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd1500;
  localparam logic [THR_W-1:0]  DEADBAND_RESET = 15'd819;

  typedef enum logic [1:0] {
    REG_GAIN,
    REG_THRESHOLD,
    REG_WINDOW,
    REG_DEADBAND
  } reg_idx_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_ROT,
    OP_MIX,
    OP_DEAD,
    OP_MAX,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_EMIT
  } op_t;

  // jump conditions; when true the step counter loads the target
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_NO_SCALE,
    JC_DIV_BUSY,
    JC_MORE_WHEELS,
    JC_OUT_BUSY
  } jc_t;

  typedef struct packed {
    op_t               op;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic no_scale;
    logic div_busy;
    logic more_wheels;
    logic out_busy;
  } seq_status_t;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_LOAD     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ROT      = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MIX      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DEAD     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MAX      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV_STEP = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIV_STORE = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd9;
  localparam logic [STEP_W-1:0] PROG_LAST     = STEP_EMIT;

  // control store
  function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    case (step)
      STEP_LOAD:      cw = '{op: OP_LOAD,      jc: JC_NO_INPUT,    target: STEP_LOAD};
      STEP_MUL:       cw = '{op: OP_MUL,       jc: JC_NEXT,        target: STEP_LOAD};
      STEP_ROT:       cw = '{op: OP_ROT,       jc: JC_NEXT,        target: STEP_LOAD};
      STEP_MIX:       cw = '{op: OP_MIX,       jc: JC_NEXT,        target: STEP_LOAD};
      STEP_DEAD:      cw = '{op: OP_DEAD,      jc: JC_NEXT,        target: STEP_LOAD};
      STEP_MAX:       cw = '{op: OP_MAX,       jc: JC_NO_SCALE,    target: STEP_EMIT};
      STEP_DIV_INIT:  cw = '{op: OP_DIV_INIT,  jc: JC_NEXT,        target: STEP_LOAD};
      STEP_DIV_STEP:  cw = '{op: OP_DIV_STEP,  jc: JC_DIV_BUSY,    target: STEP_DIV_STEP};
      STEP_DIV_STORE: cw = '{op: OP_DIV_STORE, jc: JC_MORE_WHEELS, target: STEP_DIV_INIT};
      STEP_EMIT:      cw = '{op: OP_EMIT,      jc: JC_OUT_BUSY,    target: STEP_EMIT};
      default:        cw = '{op: OP_NOP,       jc: JC_ALWAYS,      target: STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/mmhh_if.sv =====
interface mmhh_demand_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  strafe_demand;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  forward_demand;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  rotate_demand;
  logic signed [mmhh_pkg::GYRO_W-1:0]    gyro_angle;

  modport source (
    output valid, strafe_demand, forward_demand, rotate_demand, gyro_angle,
    input  ready
  );
  modport sink (
    input  valid, strafe_demand, forward_demand, rotate_demand, gyro_angle,
    output ready
  );
endinterface

interface mmhh_speed_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  front_left_speed;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  front_right_speed;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  back_right_speed;
  logic signed [mmhh_pkg::DEMAND_W-1:0]  back_left_speed;
  logic                                  heading_hold_active;

  modport source (
    output valid, front_left_speed, front_right_speed, back_right_speed,
           back_left_speed, heading_hold_active,
    input  ready
  );
  modport sink (
    input  valid, front_left_speed, front_right_speed, back_right_speed,
           back_left_speed, heading_hold_active,
    output ready
  );
endinterface

// ===== hdl/mmhh_seq.sv =====
module mmhh_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  mmhh_pkg::seq_status_t status,
  output mmhh_pkg::ctrl_word_t  ctrl
);
  import mmhh_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  // control word fetch
  assign ctrl = microcode(step);

  // jump condition select
  always_comb begin
    case (ctrl.jc)
      JC_NEXT:        take = 1'b0;
      JC_ALWAYS:      take = 1'b1;
      JC_NO_INPUT:    take = !status.in_valid;
      JC_NO_SCALE:    take = status.no_scale;
      JC_DIV_BUSY:    take = status.div_busy;
      JC_MORE_WHEELS: take = status.more_wheels;
      JC_OUT_BUSY:    take = status.out_busy;
      default:        take = 1'b1;
    endcase
    if (take) begin
      step_next = ctrl.target;
    end else if (step == PROG_LAST) begin
      step_next = STEP_LOAD;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/mecanum_mix_heading_hold_top.sv =====
// Mecanum drive mixer with gyro heading hold. One demand beat (strafe, forward,
// rotate in Q2.14, gyro heading in centidegrees) gives one speed beat of four
// Q2.14 wheel speeds and a flag that tells when the gyro term replaced the
// stick rotation. A small microprogram steps a shared datapath: the wheels are
// scaled only when a wheel exceeds 1.0, and each of the four wheels then goes
// through one radix-4 restoring divider in turn. A finished speed beat sits in
// an output register, so the block takes the next demand beat while it waits.
// Gain, stick threshold, heading window and deadband are written over the APB
// port at byte addresses 0, 4, 8 and 12; the user must write them only while
// the block is idle, since the block itself does not enforce it.
module mecanum_mix_heading_hold_top (
  input  logic                              clk,
  input  logic                              rst,
  mmhh_demand_if.sink                       demand,
  mmhh_speed_if.source                      speed,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmhh_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [mmhh_pkg::APB_W-1:0]        pwdata,
  output logic [mmhh_pkg::APB_W-1:0]        prdata,
  output logic                              pready
);
  import mmhh_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0] rotation_gain;
  logic [THR_W-1:0]  stick_rot_threshold;
  logic [WIN_W-1:0]  heading_window;
  logic [THR_W-1:0]  wheel_deadband;
  reg_idx_t          cfg_idx;

  // sequencer
  ctrl_word_t  ctrl;
  seq_status_t status;

  // datapath registers
  logic signed [DEMAND_W-1:0] x;
  logic signed [DEMAND_W-1:0] y;
  logic signed [DEMAND_W-1:0] rs;
  logic signed [GYRO_W-1:0]   g;
  logic signed [ERR_W-1:0]    err;
  logic signed [PROD_W-1:0]   prod;
  logic                       stick_wins;
  logic                       in_window;
  logic                       hold;
  logic signed [ROT_W-1:0]    r;
  logic signed [GYRO_W-1:0]   setpoint;
  logic signed [WHEEL_W-1:0]  w [4];
  logic [MAG_W-1:0]           m;
  logic [MAG_W-1:0]           rem;
  logic [QUOT_W-1:0]          num;
  logic [QUOT_W-1:0]          quot;
  logic [DCNT_W-1:0]          div_cnt;
  logic [1:0]                 wheel_cnt;

  // combinational helpers
  logic signed [MAG_W-1:0]    rs_ext;
  logic [MAG_W-1:0]           rs_mag;
  logic [ERR_W-1:0]           err_mag;
  logic signed [PROD_W-1:0]   rg_full;
  logic signed [ROT_W-1:0]    rg;
  logic                       hold_c;
  logic signed [WHEEL_W-1:0]  xw;
  logic signed [WHEEL_W-1:0]  yw;
  logic signed [WHEEL_W-1:0]  rw;
  logic [MAG_W-1:0]           wmag [4];
  logic [MAG_W-1:0]           max01;
  logic [MAG_W-1:0]           max23;
  logic [MAG_W-1:0]           max_c;
  logic [NUM_W-1:0]           numer;
  logic [MAG_W:0]             t1;
  logic [MAG_W:0]             t2;
  logic [MAG_W:0]             r1;
  logic [MAG_W:0]             r2;
  logic                       ge1;
  logic                       ge2;
  logic signed [WHEEL_W-1:0]  q_ext;
  logic signed [WHEEL_W-1:0]  q_signed;
  logic                       out_busy;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_gain       <= GAIN_RESET;
      stick_rot_threshold <= THRESH_RESET;
      heading_window      <= WINDOW_RESET;
      wheel_deadband      <= DEADBAND_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_GAIN:      rotation_gain       <= pwdata[GAIN_W-1:0];
        REG_THRESHOLD: stick_rot_threshold <= pwdata[THR_W-1:0];
        REG_WINDOW:    heading_window      <= pwdata[WIN_W-1:0];
        REG_DEADBAND:  wheel_deadband      <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN:      prdata = APB_W'(rotation_gain);
      REG_THRESHOLD: prdata = APB_W'(stick_rot_threshold);
      REG_WINDOW:    prdata = APB_W'(heading_window);
      REG_DEADBAND:  prdata = APB_W'(wheel_deadband);
      default:       prdata = '0;
    endcase
  end

  // sequencer and its status inputs
  assign out_busy           = speed.valid && !speed.ready;
  assign status.in_valid    = demand.valid;
  assign status.no_scale    = (max_c <= UNITY);
  assign status.div_busy    = (div_cnt != '0);
  assign status.more_wheels = (wheel_cnt != 2'd3);
  assign status.out_busy    = out_busy;

  mmhh_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign demand.ready = (ctrl.op == OP_LOAD);

  // magnitudes and mode decision
  assign rs_ext  = MAG_W'(rs);
  assign rs_mag  = rs_ext[MAG_W-1] ? MAG_W'(-rs_ext) : MAG_W'(rs_ext);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign hold_c  = !stick_wins && in_window;

  // gyro rotation: round to nearest, then clamp to +-2.0
  assign rg_full = (prod + ROUND_HALF) >>> 8;
  always_comb begin
    if (rg_full > ROT_SAT_HI) begin
      rg = ROT_MAX;
    end else if (rg_full < ROT_SAT_LO) begin
      rg = ROT_MIN;
    end else begin
      rg = ROT_W'(rg_full);
    end
  end

  // mix operands
  assign xw = WHEEL_W'(x);
  assign yw = WHEEL_W'(y);
  assign rw = WHEEL_W'(r);

  // wheel magnitudes and largest one
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wmag[i] = w[i][WHEEL_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
    end
    max01 = (wmag[0] > wmag[1]) ? wmag[0] : wmag[1];
    max23 = (wmag[2] > wmag[3]) ? wmag[2] : wmag[3];
    max_c = (max01 > max23) ? max01 : max23;
  end

  // divider: numerator |w| * 1.0 + m/2, two quotient bits a cycle
  assign numer = {1'b0, wmag[0], 14'b0} + NUM_W'(m[MAG_W-1:1]);
  assign t1    = {rem, num[QUOT_W-1]};
  assign ge1   = (t1 >= {1'b0, m});
  assign r1    = ge1 ? (t1 - {1'b0, m}) : t1;
  assign t2    = {r1[MAG_W-1:0], num[QUOT_W-2]};
  assign ge2   = (t2 >= {1'b0, m});
  assign r2    = ge2 ? (t2 - {1'b0, m}) : t2;

  assign q_ext    = WHEEL_W'({2'b00, quot});
  assign q_signed = w[0][WHEEL_W-1] ? -q_ext : q_ext;

  // datapath payload registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        x   <= demand.strafe_demand;
        y   <= demand.forward_demand;
        rs  <= demand.rotate_demand;
        g   <= demand.gyro_angle;
        err <= ERR_W'(demand.gyro_angle) - ERR_W'(setpoint);
      end
      OP_MUL: begin
        prod       <= $signed({1'b0, rotation_gain}) * err;
        stick_wins <= rs_mag > MAG_W'(stick_rot_threshold);
        in_window  <= err_mag < ERR_W'(heading_window);
      end
      OP_ROT: begin
        hold <= hold_c;
        r    <= hold_c ? rg : rs_ext;
      end
      OP_MIX: begin
        w[0] <= -xw + yw - rw;
        w[1] <= xw + yw + rw;
        w[2] <= -xw + yw + rw;
        w[3] <= xw + yw - rw;
      end
      OP_DEAD: begin
        for (int i = 0; i < 4; i++) begin
          if (wmag[i] < MAG_W'(wheel_deadband)) begin
            w[i] <= '0;
          end
        end
      end
      OP_MAX: begin
        m <= max_c;
      end
      OP_DIV_INIT: begin
        rem  <= MAG_W'(numer[NUM_W-1:QUOT_W]);
        num  <= numer[QUOT_W-1:0];
        quot <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= r2[MAG_W-1:0];
        num  <= {num[QUOT_W-3:0], 2'b00};
        quot <= {quot[QUOT_W-3:0], ge1, ge2};
      end
      OP_DIV_STORE: begin
        // rotate the wheels so the next one to divide sits in front
        w[0] <= w[1];
        w[1] <= w[2];
        w[2] <= w[3];
        w[3] <= q_signed;
      end
      default: ;
    endcase
  end

  // heading setpoint and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= '0;
      div_cnt   <= '0;
      wheel_cnt <= '0;
    end else begin
      case (ctrl.op)
        OP_ROT: begin
          if (!hold_c) begin
            setpoint <= g;
          end
        end
        OP_MAX: begin
          wheel_cnt <= '0;
        end
        OP_DIV_INIT: begin
          div_cnt <= DIV_STEPS;
        end
        OP_DIV_STEP: begin
          div_cnt <= div_cnt - 1'b1;
        end
        OP_DIV_STORE: begin
          wheel_cnt <= wheel_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed.valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      speed.valid <= 1'b1;
    end else if (speed.ready) begin
      speed.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      speed.front_left_speed    <= w[0][DEMAND_W-1:0];
      speed.front_right_speed   <= w[1][DEMAND_W-1:0];
      speed.back_right_speed    <= w[2][DEMAND_W-1:0];
      speed.back_left_speed     <= w[3][DEMAND_W-1:0];
      speed.heading_hold_active <= hold;
    end
  end

`ifndef SYNTHESIS
  // an accepted beat starts the program at the multiply step
  assert property (@(posedge clk) disable iff (rst)
    demand.valid && demand.ready |=> ctrl.op == OP_MUL)
    else $error("accepted beat did not start the multiply step");

  // the divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_STEP |-> rem < m)
    else $error("divider remainder not below divisor");

  // delivered wheel speeds lie within +-1.0
  assert property (@(posedge clk) disable iff (rst)
    speed.valid |->
      speed.front_left_speed >= -16'sd16384 && speed.front_left_speed <= 16'sd16384 &&
      speed.front_right_speed >= -16'sd16384 && speed.front_right_speed <= 16'sd16384 &&
      speed.back_right_speed >= -16'sd16384 && speed.back_right_speed <= 16'sd16384 &&
      speed.back_left_speed >= -16'sd16384 && speed.back_left_speed <= 16'sd16384)
    else $error("wheel speed outside unit range");

  // the setpoint moves only in the rotation step
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(setpoint) |-> $past(ctrl.op) == OP_ROT)
    else $error("heading setpoint changed outside the rotation step");
`endif

endmodule
